/* rtl/wmf_pkg.sv */
// Shared types and constants for the window mode filter.
// Used by every module under rtl except wmf_ram; depends on nothing else.
package wmf_pkg;

   // Default sizes for the top level parameters.
   localparam int MAX_WINDOW_DEF = 11;
   localparam int MAX_LINE_DEF   = 1024;

   // Field and register widths.
   localparam int SAMPLE_W       = 8;
   localparam int WIN_SIZE_W     = 4;
   localparam int LINE_WIDTH_W   = 11;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_INDEX_W    = 2;
   localparam int ROW_W          = 12;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [WIN_SIZE_W-1:0]   WIN_SIZE_RST   = 4'd3;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd504;

   // Row counter saturates here.
   localparam logic [ROW_W-1:0] ROW_LIMIT = 12'hFFF;

   // Request and response payloads.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_start;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mode_value;
      logic                row_end;
   } rsp_type;

   // One value traveling along the cell chain.
   typedef struct packed {
      logic                vld;
      logic [SAMPLE_W-1:0] val;
   } token_type;

   // Control broadcast to all cells.
   typedef struct packed {
      logic load;
      logic rotate;
      logic scan;
   } cell_ctl_type;

   // Handshake between the top level and the cell chain.
   typedef struct packed {
      logic start;
      logic take;
   } chain_req_type;

   typedef struct packed {
      logic hold;
   } chain_sts_type;

   typedef enum logic [1:0] {
      CH_IDLE,
      CH_COUNT,
      CH_SCAN,
      CH_HOLD
   } chain_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LAUNCH,
      ST_RUN
   } top_state_type;

endpackage

/* rtl/wmf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; no package needed.
module wmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/wmf_cell.sv */
// One cell of the counting chain: holds one window value and its count.
// Depends on wmf_pkg.
module wmf_cell #(
   parameter int CNT_W = 8
) (
   input  logic                    clock,
   input  wmf_pkg::cell_ctl_type   ctl,
   input  wmf_pkg::token_type      load_tok,
   input  wmf_pkg::token_type      tok_in,
   output wmf_pkg::token_type      tok_out,
   input  wmf_pkg::token_type      rec_in,
   input  logic [CNT_W-1:0]        cnt_in,
   output wmf_pkg::token_type      rec_out,
   output logic [CNT_W-1:0]        cnt_out
);
   import wmf_pkg::*;

   token_type        own_ff, own_in;
   token_type        tok_ff, tok_in_nx;
   logic [CNT_W-1:0] cnt_ff, cnt_in_nx;

   // Load takes the window value, rotate counts the passing value, scan shifts
   // the value and count on toward the end of the chain.
   always_comb begin
      own_in    = own_ff;
      tok_in_nx = tok_ff;
      cnt_in_nx = cnt_ff;
      if (ctl.load) begin
         own_in    = load_tok;
         tok_in_nx = load_tok;
         cnt_in_nx = '0;
      end else if (ctl.rotate) begin
         if (tok_ff.vld && own_ff.vld && (tok_ff.val == own_ff.val)) begin
            cnt_in_nx = cnt_ff + 1'b1;
         end
         tok_in_nx = tok_in;
      end else if (ctl.scan) begin
         own_in    = rec_in;
         cnt_in_nx = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      own_ff <= own_in;
      tok_ff <= tok_in_nx;
      cnt_ff <= cnt_in_nx;
   end

   assign tok_out = tok_ff;
   assign rec_out = own_ff;
   assign cnt_out = cnt_ff;

endmodule

/* rtl/wmf_chain.sv */
// Ring of counting cells with its sequencer and the final best-value compare.
// Depends on wmf_pkg and wmf_cell.
module wmf_chain #(
   parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  wmf_pkg::chain_req_type                         req,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]                n_eff,
   input  logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0][7:0]     window,
   output wmf_pkg::chain_sts_type                         sts,
   output logic [7:0]                                     mode_value
);
   import wmf_pkg::*;

   localparam int M     = MAX_WINDOW * MAX_WINDOW;
   localparam int NW    = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W = $clog2(M + 1);
   localparam int PH_W  = $clog2(M);

   chain_state_type  state_ff, state_in;
   logic [PH_W-1:0]  ph_ff, ph_in;
   cell_ctl_type     ctl;
   logic [7:0]       best_val_ff, best_val_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;

   token_type        tok   [M];
   token_type        rec   [M];
   logic [CNT_W-1:0] cnt   [M];

   // Cells: position c*MAX+r holds window column c, row r; the ring closes
   // from the last cell back to the first.
   for (genvar i = 0; i < M; i++) begin : g_cell
      localparam int C = i / MAX_WINDOW;
      localparam int R = i % MAX_WINDOW;
      token_type        load_tok;
      token_type        ring_in;
      token_type        scan_rec;
      logic [CNT_W-1:0] scan_cnt;

      assign load_tok.val = window[C][R];
      assign load_tok.vld = (NW'(C) < n_eff) && (NW'(R) < n_eff);

      if (i == 0) begin : g_head
         assign ring_in  = tok[M-1];
         assign scan_rec = '0;
         assign scan_cnt = '0;
      end else begin : g_body
         assign ring_in  = tok[i-1];
         assign scan_rec = rec[i-1];
         assign scan_cnt = cnt[i-1];
      end

      wmf_cell #(.CNT_W(CNT_W)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_tok (load_tok),
         .tok_in   (ring_in),
         .tok_out  (tok[i]),
         .rec_in   (scan_rec),
         .cnt_in   (scan_cnt),
         .rec_out  (rec[i]),
         .cnt_out  (cnt[i])
      );
   end

   // Sequencer: one full ring rotation to count, then one pass to scan out.
   always_comb begin
      state_in    = state_ff;
      ph_in       = ph_ff;
      ctl         = '0;
      best_val_in = best_val_ff;
      best_cnt_in = best_cnt_ff;
      case (state_ff)
         CH_IDLE: begin
            if (req.start) begin
               ctl.load = 1'b1;
               ph_in    = '0;
               state_in = CH_COUNT;
            end
         end
         CH_COUNT: begin
            ctl.rotate = 1'b1;
            ph_in      = ph_ff + 1'b1;
            if (ph_ff == PH_W'(M - 1)) begin
               ph_in       = '0;
               best_cnt_in = '0;
               best_val_in = '0;
               state_in    = CH_SCAN;
            end
         end
         CH_SCAN: begin
            ctl.scan = 1'b1;
            ph_in    = ph_ff + 1'b1;
            // Higher count wins; on equal count the smaller value wins.
            if (rec[M-1].vld && ((cnt[M-1] > best_cnt_ff) ||
                ((cnt[M-1] == best_cnt_ff) && (rec[M-1].val < best_val_ff)))) begin
               best_cnt_in = cnt[M-1];
               best_val_in = rec[M-1].val;
            end
            if (ph_ff == PH_W'(M - 1)) begin
               state_in = CH_HOLD;
            end
         end
         CH_HOLD: begin
            if (req.take) begin
               state_in = CH_IDLE;
            end
         end
         default: begin
            state_in = CH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CH_IDLE;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
      end
      best_val_ff <= best_val_in;
      best_cnt_ff <= best_cnt_in;
   end

   assign sts.hold   = (state_ff == CH_HOLD);
   assign mode_value = best_val_ff;

   // A new start is only issued while the chain is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == CH_IDLE)
      else $error("chain started while busy");

   // The count phase always hands over to the scan phase.
   a_count_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CH_COUNT && ph_ff == PH_W'(M - 1)) |=> state_ff == CH_SCAN)
      else $error("count phase did not end in scan");

   // The result is held until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CH_HOLD && !req.take) |=> state_ff == CH_HOLD)
      else $error("chain result dropped");

endmodule

/* rtl/window_mode_filter_unit.sv */
// Window mode filter: takes one padded sample per request in raster order and,
// for every position where a full N by N window fits, returns the most
// frequent window value, the smallest one on a tie. A request that yields a
// result occupies the block until the ring of MAX_WINDOW squared counting
// cells is done: one full rotation counts every value, one shift pass picks
// the winner. No new request is taken until the current one is through, with
// or without a result. The line store is one RAM per buffered line, read and
// written at the current column in the same cycle.
// A finished response waits in an output register while the next request is
// taken. Writing either configuration register restarts the frame counters.
module window_mode_filter_unit #(
   parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = wmf_pkg::MAX_LINE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  wmf_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output wmf_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_we,
   input  logic [wmf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [wmf_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import wmf_pkg::*;

   localparam int NW = $clog2(MAX_WINDOW + 1);
   localparam int SW = $clog2(MAX_WINDOW - 1);
   localparam int AW = $clog2(MAX_LINE);
   localparam int LW = $clog2(MAX_LINE + 1);
   localparam int CW = (LW > LINE_WIDTH_W) ? LW : LINE_WIDTH_W;

   top_state_type            state_ff, state_in;
   logic [WIN_SIZE_W-1:0]    ws_ff, ws_in;
   logic [LINE_WIDTH_W-1:0]  lw_ff, lw_in;
   logic [AW-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [SW-1:0]            slot_ff, slot_in;
   logic [7:0]               s_ff, s_in;
   logic                     prod_ff, prod_in;
   logic                     rend_ff, rend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0][7:0] win_ff, win_in;

   logic [WIN_SIZE_W-1:0]    ws_odd;
   logic [NW-1:0]            n_eff, nm1;
   logic [CW-1:0]            lw_ext;
   logic [LW-1:0]            w_eff;
   logic                     accept, rsp_free, restart;
   logic [AW-1:0]            col_cur;
   logic [ROW_W-1:0]         row_cur;
   logic [SW-1:0]            slot_cur;
   logic [LW-1:0]            col_next;
   logic [7:0]               rd_data [MAX_WINDOW];
   logic [MAX_WINDOW-1:0][7:0] new_col;
   chain_req_type            chain_req;
   chain_sts_type            chain_sts;
   logic [7:0]               chain_mode;

   // Effective window size: odd, clamped to 3..MAX_WINDOW.
   always_comb begin
      ws_odd = ws_ff | WIN_SIZE_W'(1);
      if (ws_odd < WIN_SIZE_W'(3)) begin
         n_eff = NW'(3);
      end else if ({1'b0, ws_odd} > (WIN_SIZE_W+1)'(MAX_WINDOW)) begin
         n_eff = NW'(MAX_WINDOW);
      end else begin
         n_eff = NW'(ws_odd);
      end
      nm1 = n_eff - 1'b1;
   end

   // Effective line width: clamped to 3..MAX_LINE.
   always_comb begin
      lw_ext = CW'(lw_ff);
      if (lw_ext < CW'(3)) begin
         w_eff = LW'(3);
      end else if (lw_ext > CW'(MAX_LINE)) begin
         w_eff = LW'(MAX_LINE);
      end else begin
         w_eff = LW'(lw_ext);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign restart   = csr_we && ((csr_index == CSR_WINDOW_SIZE) ||
                                 (csr_index == CSR_LINE_WIDTH));

   // Position of the accepted sample; a frame start zeroes the counters first.
   assign col_cur  = req_data.frame_start ? '0 : col_ff;
   assign row_cur  = req_data.frame_start ? '0 : row_ff;
   assign slot_cur = req_data.frame_start ? '0 : slot_ff;
   assign col_next = LW'(col_cur) + 1'b1;

   // Line store: one RAM for each buffered line.
   for (genvar k = 0; k < MAX_WINDOW - 1; k++) begin : g_line
      wmf_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_ram (
         .clock   (clock),
         .wr_en   (accept && (slot_cur == SW'(k))),
         .wr_addr (col_cur),
         .wr_data (req_data.sample),
         .rd_addr (col_cur),
         .rd_data (rd_data[k])
      );
   end
   assign rd_data[MAX_WINDOW-1] = '0;

   // New window column: buffered lines on top, the new sample below them.
   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (k < int'(n_eff) - 1) begin
            new_col[k] = rd_data[k];
         end else if (k == int'(n_eff) - 1) begin
            new_col[k] = s_ff;
         end else begin
            new_col[k] = win_ff[0][k];
         end
      end
   end

   // Control flow and counter updates.
   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      lw_in        = lw_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      rend_in      = rend_ff;
      win_in       = win_ff;
      chain_req    = '0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in    = req_data.sample;
               prod_in = (ROW_W'(nm1) <= row_cur) && (LW'(nm1) <= LW'(col_cur));
               rend_in = (LW'(col_cur) == (w_eff - 1'b1));
               if (col_next >= w_eff) begin
                  col_in  = '0;
                  row_in  = (row_cur < ROW_LIMIT) ? row_cur + 1'b1 : row_cur;
                  slot_in = ((NW'(slot_cur) + 1'b1) >= nm1) ? '0 : slot_cur + 1'b1;
               end else begin
                  col_in  = AW'(col_next);
                  row_in  = row_cur;
                  slot_in = slot_cur;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The line store data for the accepted column is valid only now.
            for (int c = MAX_WINDOW - 1; c > 0; c--) begin
               win_in[c] = win_ff[c-1];
            end
            win_in[0] = new_col;
            state_in  = prod_ff ? ST_LAUNCH : ST_IDLE;
         end
         ST_LAUNCH: begin
            chain_req.start = 1'b1;
            state_in        = ST_RUN;
         end
         ST_RUN: begin
            if (chain_sts.hold && rsp_free) begin
               chain_req.take         = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_data_in.mode_value = chain_mode;
               rsp_data_in.row_end    = rend_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write registers only in idle (unchecked); a write restarts the frame.
      if (csr_we && (csr_index == CSR_WINDOW_SIZE)) begin
         ws_in = csr_wdata[WIN_SIZE_W-1:0];
      end
      if (csr_we && (csr_index == CSR_LINE_WIDTH)) begin
         lw_in = csr_wdata[LINE_WIDTH_W-1:0];
      end
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= WIN_SIZE_RST;
         lw_ff        <= LINE_WIDTH_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         lw_ff        <= lw_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      rend_ff     <= rend_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   wmf_chain #(.MAX_WINDOW(MAX_WINDOW)) u_chain (
      .clock      (clock),
      .reset      (reset),
      .req        (chain_req),
      .n_eff      (n_eff),
      .window     (win_ff),
      .sts        (chain_sts),
      .mode_value (chain_mode)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The column counter always stays inside the line.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      LW'(col_ff) < w_eff)
      else $error("column counter beyond line width");

   // The write slot always names one of the buffered lines in use.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      NW'(slot_ff) < nm1)
      else $error("write slot beyond buffered lines");

   // A finished result moves into the output register.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && chain_sts.hold && rsp_free) |=> rsp_valid_ff)
      else $error("finished result not presented");

   // An accepted request goes on to the line store read.
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted request not processed");

endmodule
